// ----- src/txrb_pkg.sv -----
// ----------------------------------------------------------------------------
// txrb_pkg
// Shared types and constants for the transmit ring buffer with segment drain.
// ----------------------------------------------------------------------------
package txrb_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_RESERVE = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_FETCH   = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_ROOM     = 2'd1,
    ST_IN_PROGRESS = 2'd2,
    ST_IGNORED     = 2'd3
  } status_e;

  // input transaction
  typedef struct packed {
    kind_e       kind;
    logic [11:0] msg_length;
    logic [7:0]  byte_in;
    logic [11:0] fetch_addr;
  } item_t;

  // result transaction
  typedef struct packed {
    status_e     status;
    logic        start_valid;
    logic [11:0] start_offset;
    logic [12:0] start_length;
    logic [7:0]  byte_out;
    logic [31:0] lost_count;
    logic        draining;
  } result_t;

  // classified command between front and back
  typedef struct packed {
    kind_e       op;
    logic        zero_len;
    logic [11:0] msg_length;
    logic [7:0]  byte_in;
    logic [11:0] fetch_addr;
  } cmd_t;

  // result write from back to the result queue
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_push_t;

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned RESQ_DEPTH = 4;
  localparam logic [31:0] LOST_MAX   = 32'hFFFF_FFFF;

endpackage

// ----- src/txrb_front.sv -----
// ----------------------------------------------------------------------------
// txrb_front
// Accepts input transactions, classifies them and buffers them for the back.
// ----------------------------------------------------------------------------
module txrb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  txrb_pkg::item_t   in_item_i,
  input  logic              cmd_pop_i,
  output logic              cmd_valid_o,
  output txrb_pkg::cmd_t    cmd_o
);

  localparam int unsigned QW = $clog2(txrb_pkg::CMDQ_DEPTH);

  txrb_pkg::cmd_t cmd_new;
  txrb_pkg::cmd_t q_mem [txrb_pkg::CMDQ_DEPTH];
  logic [QW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QW:0]    cnt_q, cnt_d;
  logic           do_push, do_pop;

  // classify the incoming item
  always_comb begin
    cmd_new.op         = in_item_i.kind;
    cmd_new.zero_len   = (in_item_i.msg_length == 12'd0);
    cmd_new.msg_length = in_item_i.msg_length;
    cmd_new.byte_in    = in_item_i.byte_in;
    cmd_new.fetch_addr = in_item_i.fetch_addr;
  end

  // queue control
  assign full        = (cnt_q == (QW+1)'(txrb_pkg::CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign do_push     = push & ~full;
  assign do_pop      = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = q_mem[rp_q];

  always_comb begin
    wp_d  = do_push ? wp_q + QW'(1) : wp_q;
    rp_d  = do_pop ? rp_q + QW'(1) : rp_q;
    cnt_d = cnt_q + (QW+1)'(do_push) - (QW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wp_q] <= cmd_new;
    end
  end

  // occupancy stays within the queue depth
  a_cmdq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QW+1)'(txrb_pkg::CMDQ_DEPTH))
    else $error("command queue overflow");

endmodule

// ----- src/txrb_back.sv -----
// ----------------------------------------------------------------------------
// txrb_back
// Executes commands: admission, ring writes, drain segments and fetch reads.
// ----------------------------------------------------------------------------
module txrb_back #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  input  txrb_pkg::cmd_t                        cmd_i,
  output logic                                  cmd_pop_o,
  input  logic [$clog2(txrb_pkg::RESQ_DEPTH):0] oq_cnt_i,
  output txrb_pkg::res_push_t                   res_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam int unsigned RW = $clog2(txrb_pkg::RESQ_DEPTH) + 2;

  logic [AW-1:0]    rd_q, rd_d, wr_q, wr_d, nrd_q, nrd_d;
  logic [AW-1:0]    rd_n, wr_n;
  logic             busy_q, busy_d, busy_n;
  logic [11:0]      pend_q, pend_d;
  logic [31:0]      lost_q, lost_d;
  logic [CW-1:0]    free_w, depth_w, len_w, ofs_w, fa_w;
  logic             go, trig, issue, wrap_rd, mem_we, mem_re;
  txrb_pkg::status_e status;
  txrb_pkg::result_t res_d, res_pay_q;
  logic             res_vld_q, fetch_q;
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [7:0]       rdata_q;

  // issue only when the result queue has a slot for the in-flight result too
  assign go = cmd_valid_i &&
              ((RW'(oq_cnt_i) + RW'(res_vld_q)) < RW'(txrb_pkg::RESQ_DEPTH));
  assign cmd_pop_o = go;

  // free space with one slot kept empty
  assign depth_w = CW'(RING_DEPTH);
  assign free_w  = (wr_q >= rd_q) ? CW'(rd_q) + depth_w - CW'(wr_q) - CW'(1)
                                  : CW'(rd_q) - CW'(wr_q) - CW'(1);
  assign fa_w    = CW'(cmd_i.fetch_addr);

  // command execution
  always_comb begin
    status = txrb_pkg::ST_OK;
    trig   = 1'b0;
    rd_n   = rd_q;
    wr_n   = wr_q;
    busy_n = busy_q;
    pend_d = pend_q;
    lost_d = lost_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    if (go) begin
      case (cmd_i.op)
        txrb_pkg::KIND_RESERVE: begin
          if (pend_q != 12'd0) begin
            status = txrb_pkg::ST_IN_PROGRESS;
          end else if (CW'(cmd_i.msg_length) > free_w) begin
            status = txrb_pkg::ST_NO_ROOM;
            if (lost_q != txrb_pkg::LOST_MAX) begin
              lost_d = lost_q + 32'd1;
            end
          end else begin
            pend_d = cmd_i.msg_length;
            trig   = cmd_i.zero_len;
          end
        end
        txrb_pkg::KIND_DATA: begin
          if (pend_q == 12'd0) begin
            status = txrb_pkg::ST_IGNORED;
          end else begin
            mem_we = 1'b1;
            wr_n   = (wr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_q + AW'(1);
            pend_d = pend_q - 12'd1;
            trig   = (pend_q == 12'd1);
          end
        end
        txrb_pkg::KIND_DONE: begin
          if (busy_q) begin
            rd_n   = nrd_q;
            busy_n = 1'b0;
            trig   = 1'b1;
          end
        end
        txrb_pkg::KIND_FETCH: begin
          mem_re = 1'b1;
        end
        default: begin
          status = txrb_pkg::ST_OK;
        end
      endcase
    end
  end

  // drain segment issue on the updated pointers
  always_comb begin
    issue   = trig & ~busy_n & (rd_n != wr_n);
    wrap_rd = (rd_n > wr_n);
    ofs_w   = CW'(rd_n);
    len_w   = wrap_rd ? depth_w - CW'(rd_n) : CW'(wr_n) - CW'(rd_n);
    nrd_d   = issue ? (wrap_rd ? '0 : wr_n) : nrd_q;
    busy_d  = issue | busy_n;
    rd_d    = rd_n;
    wr_d    = wr_n;
  end

  // result fields
  always_comb begin
    res_d.status       = status;
    res_d.start_valid  = issue;
    res_d.start_offset = issue ? ofs_w[11:0] : 12'd0;
    res_d.start_length = issue ? len_w[12:0] : 13'd0;
    res_d.byte_out     = 8'd0;
    res_d.lost_count   = lost_d;
    res_d.draining     = busy_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q      <= '0;
      wr_q      <= '0;
      nrd_q     <= '0;
      busy_q    <= 1'b0;
      pend_q    <= '0;
      lost_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      nrd_q     <= nrd_d;
      busy_q    <= busy_d;
      pend_q    <= pend_d;
      lost_q    <= lost_d;
      res_vld_q <= go;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (go) begin
      res_pay_q <= res_d;
      fetch_q   <= mem_re;
    end
  end

  // ring memory, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_q] <= cmd_i.byte_in;
    end
    if (mem_re) begin
      rdata_q <= ring_mem[fa_w[AW-1:0]];
    end
  end

  // merge read data into the registered result
  always_comb begin
    res_o.valid        = res_vld_q;
    res_o.res          = res_pay_q;
    res_o.res.byte_out = fetch_q ? rdata_q : 8'd0;
  end

  // an issued segment leaves the drain busy
  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_pay_q.start_valid |-> busy_q)
    else $error("segment issued without drain busy");

  // lost counter never goes backwards
  a_lost_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> lost_q >= $past(lost_q))
    else $error("lost counter decreased");

  // an accepted data byte advances the write pointer
  a_wr_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (cmd_i.op == txrb_pkg::KIND_DATA) && (pend_q != 12'd0)
    |=> wr_q != $past(wr_q))
    else $error("write pointer did not advance");

endmodule

// ----- src/txrb_outq.sv -----
// ----------------------------------------------------------------------------
// txrb_outq
// Result queue that decouples the back from the consumer.
// ----------------------------------------------------------------------------
module txrb_outq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  txrb_pkg::res_push_t                   res_i,
  input  logic                                  pop,
  output logic                                  empty,
  output txrb_pkg::result_t                     result_o,
  output logic [$clog2(txrb_pkg::RESQ_DEPTH):0] cnt_o
);

  localparam int unsigned QW = $clog2(txrb_pkg::RESQ_DEPTH);

  txrb_pkg::result_t q_mem [txrb_pkg::RESQ_DEPTH];
  logic [QW-1:0]     wp_q, rp_q;
  logic [QW:0]       cnt_q;
  logic              do_pop;

  assign empty    = (cnt_q == '0);
  assign do_pop   = pop & ~empty;
  assign result_o = q_mem[rp_q];
  assign cnt_o    = cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (res_i.valid) begin
        wp_q <= wp_q + QW'(1);
      end
      if (do_pop) begin
        rp_q <= rp_q + QW'(1);
      end
      cnt_q <= cnt_q + (QW+1)'(res_i.valid) - (QW+1)'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      q_mem[wp_q] <= res_i.res;
    end
  end

  // the back never writes into a full queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> cnt_q < (QW+1)'(txrb_pkg::RESQ_DEPTH))
    else $error("result queue overrun");

endmodule

// ----- src/tx_ring_buffer_dma_scheduler.sv -----
// ----------------------------------------------------------------------------
// tx_ring_buffer_dma_scheduler
// Transmit byte ring with all-or-nothing message admission and a drain that
// hands out one contiguous segment at a time. Every input transaction gives
// exactly one result transaction. Sustained rate is one transaction per
// cycle while results are popped promptly. An accepted input is written into
// the command queue; the execute stage then takes it and registers its result,
// with the ring memory access, into the result register, from which the result
// queue takes it and shows it on the result ports. The execute stage holds all
// pointer state and issues one command per cycle, gated only by space in the
// result queue. RING_DEPTH must be a power of two; the ring memory has no
// reset and a fetch of a never-written entry returns an arbitrary byte. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module tx_ring_buffer_dma_scheduler #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  txrb_pkg::item_t   in_item_i,
  output logic              empty,
  input  logic              pop,
  output txrb_pkg::result_t result_o
);

  logic                                  cmd_valid, cmd_pop;
  txrb_pkg::cmd_t                        cmd;
  txrb_pkg::res_push_t                   res_push;
  logic [$clog2(txrb_pkg::RESQ_DEPTH):0] oq_cnt;

  // front: accept and classify
  txrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // back: execute against ring and pointers
  txrb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .oq_cnt_i    (oq_cnt),
    .res_o       (res_push)
  );

  // result queue
  txrb_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (res_push),
    .pop      (pop),
    .empty    (empty),
    .result_o (result_o),
    .cnt_o    (oq_cnt)
  );

endmodule
